// ===== hw/rtl/u16u32_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-16 to UTF-32 decoder package
// Shared constants and types for the code unit decoder and its result buffer.
// ----------------------------------------------------------------------------
package u16u32_pkg;

  // Code units carried by one request.
  localparam int unsigned UNIT_FIELDS = 4;
  localparam int unsigned UNIT_W      = 16;
  localparam int unsigned COUNT_W     = 3;
  localparam int unsigned CP_W        = 21;
  localparam int unsigned PAYLOAD_W   = 10;

  // Surrogate classification: top six bits of a unit.
  localparam logic [UNIT_W-1:0] SURR_MASK = 16'hfc00;
  localparam logic [UNIT_W-1:0] HIGH_TAG  = 16'hd800;
  localparam logic [UNIT_W-1:0] LOW_TAG   = 16'hdc00;
  localparam logic [CP_W-1:0]   PLANE_OFFSET = 21'h010000;

  typedef logic [UNIT_FIELDS-1:0][UNIT_W-1:0] unit_arr_t;

  // One decoded result.
  typedef struct packed {
    logic [CP_W-1:0] code_point;
    logic            error;
  } result_t;

endpackage

// ===== hw/rtl/u16u32_decode.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-16 code unit decoder
// Walks the units of one request, pairs surrogates and builds the packed list
// of results. Holds the pending high surrogate and the sticky error flag.
// ----------------------------------------------------------------------------
module u16u32_decode #(
  parameter int unsigned DEPTH = 4
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                take_i,
  input  u16u32_pkg::unit_arr_t               units_i,
  input  logic [u16u32_pkg::COUNT_W-1:0]      unit_count_i,
  input  logic                                end_of_stream_i,
  output u16u32_pkg::result_t [DEPTH-1:0]     res_o,
  output logic [$clog2(DEPTH+1)-1:0]          res_count_o
);

  localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [u16u32_pkg::PAYLOAD_W-1:0] pend_bits_q, pend_bits_d;
  logic                             pend_vld_q, pend_vld_d;
  logic                             err_q, err_d;

  always_comb begin
    logic [u16u32_pkg::COUNT_W-1:0] cnt;
    logic [2:0]                     n;
    logic [u16u32_pkg::UNIT_W-1:0]  u;
    logic [u16u32_pkg::UNIT_W-1:0]  tag;
    logic                           err;
    logic                           pv;
    logic [u16u32_pkg::PAYLOAD_W-1:0] pb;

    cnt = (unit_count_i > u16u32_pkg::COUNT_W'(DEPTH)) ?
          u16u32_pkg::COUNT_W'(DEPTH) : unit_count_i;
    n   = '0;
    err = 1'b0;
    pv  = pend_vld_q;
    pb  = pend_bits_q;
    u   = '0;
    tag = '0;
    res_o = '0;

    if (err_q) begin
      // Decoding has stopped: answer every request with one error result.
      res_o[0].error = 1'b1;
      n   = 3'd1;
      err = 1'b1;
    end else begin
      for (int i = 0; i < u16u32_pkg::UNIT_FIELDS; i++) begin
        if ((u16u32_pkg::COUNT_W'(i) < cnt) && !err) begin
          u   = units_i[i];
          tag = u & u16u32_pkg::SURR_MASK;
          if (tag == u16u32_pkg::HIGH_TAG) begin
            if (pv) begin
              err = 1'b1;
            end else begin
              pb = u[u16u32_pkg::PAYLOAD_W-1:0];
              pv = 1'b1;
            end
          end else if (tag == u16u32_pkg::LOW_TAG) begin
            if (pv) begin
              if (n < 3'(DEPTH)) begin
                res_o[n[IDX_W-1:0]].code_point = u16u32_pkg::PLANE_OFFSET
                    + {1'b0, pb, 10'b0}
                    + {11'b0, u[u16u32_pkg::PAYLOAD_W-1:0]};
              end
              n  = n + 3'd1;
              pv = 1'b0;
              pb = '0;
            end else begin
              err = 1'b1;
            end
          end else begin
            if (pv) begin
              err = 1'b1;
            end else begin
              if (n < 3'(DEPTH)) begin
                res_o[n[IDX_W-1:0]].code_point = {5'b0, u};
              end
              n = n + 3'd1;
            end
          end
        end
      end

      // A high surrogate left over at end of stream is unpaired.
      if (!err && end_of_stream_i && pv) begin
        err = 1'b1;
      end

      if (err) begin
        pv = 1'b0;
        pb = '0;
        if (n < 3'(DEPTH)) begin
          res_o[n[IDX_W-1:0]].error = 1'b1;
        end
        n = n + 3'd1;
      end
    end

    res_count_o = n[CNT_W-1:0];
    pend_vld_d  = pv;
    pend_bits_d = pb;
    err_d       = err;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_bits_q <= '0;
      pend_vld_q  <= 1'b0;
      err_q       <= 1'b0;
    end else if (take_i) begin
      pend_bits_q <= pend_bits_d;
      pend_vld_q  <= pend_vld_d;
      err_q       <= err_d;
    end
  end

endmodule

// ===== hw/rtl/u16u32_out_buf.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-32 result buffer
// Holds one request's results and sends one per cycle while the sink is ready.
// ----------------------------------------------------------------------------
module u16u32_out_buf #(
  parameter int unsigned DEPTH = 4
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             load_i,
  input  u16u32_pkg::result_t [DEPTH-1:0]  res_i,
  input  logic [$clog2(DEPTH+1)-1:0]       res_count_i,
  output logic                             ready_o,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output u16u32_pkg::result_t              out_res_o,
  output logic                             out_last_o
);

  localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  u16u32_pkg::result_t [DEPTH-1:0] res_q;
  logic [CNT_W-1:0]                cnt_q;
  logic [IDX_W-1:0]                idx_q;
  logic                            vld_q;
  logic                            pop;

  assign out_valid_o = vld_q;
  assign out_res_o   = res_q[idx_q];
  assign out_last_o  = (CNT_W'(idx_q) + CNT_W'(1)) == cnt_q;
  assign pop         = vld_q && out_ready_i;
  assign ready_o     = !vld_q || (out_ready_i && out_last_o);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
      idx_q <= '0;
    end else if (load_i) begin
      vld_q <= 1'b1;
      idx_q <= '0;
    end else if (pop) begin
      if (out_last_o) begin
        vld_q <= 1'b0;
        idx_q <= '0;
      end else begin
        idx_q <= idx_q + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
      cnt_q <= res_count_i;
    end
  end

endmodule

// ===== hw/rtl/utf16_to_utf32_decoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-16 to UTF-32 stream decoder
// Decodes up to four UTF-16 code units per request into Unicode scalar values,
// pairing surrogates across requests and flagging unpaired ones.
// ----------------------------------------------------------------------------
//
// Channel   Dir  Payload                                          Done when
// s_axis    in   tdata: unit_a,b,c,d, unit_count; tlast: eos      tvalid & tready
// m_axis    out  tdata: code_point; tuser: error; tlast: last     tvalid & tready
//
// Output: a request yields 0 to min(4, UNITS_PER_ITEM) results, and the output
//   moves one per cycle while m_axis_tready is high; one with none only updates
//   the decoder state. Units pass the input register, then the result buffer.
// Reset: clears the pending surrogate, the sticky error and both valid flags.
// Stalls: a new request enters the input register while the buffer drains and
//   is decoded into the buffer in the cycle its last result is taken.
// ----------------------------------------------------------------------------
module utf16_to_utf32_decoder #(
  parameter int unsigned UNITS_PER_ITEM = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // tdata, from bit 0: unit_a[15:0], unit_b[15:0], unit_c[15:0], unit_d[15:0],
  // unit_count[2:0], zero fill to 72 bits
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [71:0] s_axis_tdata_i,
  input  logic        s_axis_tlast_i,   // end_of_stream
  // tdata, from bit 0: code_point[20:0], zero fill to 24 bits
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o,
  output logic        m_axis_tuser_o,   // error
  output logic        m_axis_tlast_o    // last_of_item
);

  // Results per request never exceed the saturated unit count.
  localparam int unsigned DEPTH = (UNITS_PER_ITEM < u16u32_pkg::UNIT_FIELDS) ?
                                  UNITS_PER_ITEM : u16u32_pkg::UNIT_FIELDS;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  // Input register.
  u16u32_pkg::unit_arr_t              units_q;
  logic [u16u32_pkg::COUNT_W-1:0]     count_q;
  logic                               eos_q;
  logic                               in_vld_q;

  u16u32_pkg::result_t [DEPTH-1:0]    dec_res;
  logic [CNT_W-1:0]                   dec_count;
  u16u32_pkg::result_t                out_res;
  logic                               buf_ready;
  logic                               take;
  logic                               s_fire;

  // Decode the held request as soon as the buffer can take its results.
  assign take            = in_vld_q && buf_ready;
  assign s_axis_tready_o = !in_vld_q || take;
  assign s_fire          = s_axis_tvalid_i && s_axis_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_fire) begin
      in_vld_q <= 1'b1;
    end else if (take) begin
      in_vld_q <= 1'b0;
    end
  end

  // Hold the payload until the request is decoded.
  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      for (int i = 0; i < u16u32_pkg::UNIT_FIELDS; i++) begin
        units_q[i] <= s_axis_tdata_i[i*u16u32_pkg::UNIT_W +: u16u32_pkg::UNIT_W];
      end
      count_q <= s_axis_tdata_i[64 +: u16u32_pkg::COUNT_W];
      eos_q   <= s_axis_tlast_i;
    end
  end

  u16u32_decode #(
    .DEPTH (DEPTH)
  ) u_decode (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .take_i          (take),
    .units_i         (units_q),
    .unit_count_i    (count_q),
    .end_of_stream_i (eos_q),
    .res_o           (dec_res),
    .res_count_o     (dec_count)
  );

  // A request with no results only advances the decoder state.
  u16u32_out_buf #(
    .DEPTH (DEPTH)
  ) u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (take && (dec_count != '0)),
    .res_i       (dec_res),
    .res_count_i (dec_count),
    .ready_o     (buf_ready),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_res_o   (out_res),
    .out_last_o  (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {3'b0, out_res.code_point};
  assign m_axis_tuser_o = out_res.error;

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench for the UTF-16 to UTF-32 stream decoder
// Drives requests of up to four code units into the decoder and checks every
// result against a shadow decoder. The shadow decoder pairs surrogates across
// requests and keeps its own sticky fault. Directed requests cover plain units
// at the range limits, surrogate pairs inside one request and across two, and
// zero or oversized unit counts. Random requests follow, and both sides stall
// in bursts. One unpaired surrogate ends the run, followed by requests that
// must each return a lone error result.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int unsigned UNITS_PER_ITEM = 4;
  // Count saturates at the smaller of the port width and the parameter.
  localparam int unsigned MAX_UNITS =
    (UNITS_PER_ITEM < u16u32_pkg::UNIT_FIELDS) ? UNITS_PER_ITEM : u16u32_pkg::UNIT_FIELDS;
  localparam int QUIET_LIMIT = 2000;  // cycles with no transfer on either side
  localparam int MAX_REPORTS = 10;
  localparam int TAIL_CYCLES = 16;

  // One decoded result as the output port should present it.
  typedef struct packed {
    u16u32_pkg::result_t res;
    logic                last;
  } point_t;

  // Ways to break the stream in the closing test.
  typedef enum int {
    FAULT_HIGH_HIGH,
    FAULT_HIGH_PLAIN,
    FAULT_LONE_LOW,
    FAULT_EOS_OPEN
  } fault_e;

  logic        clk      = 1'b0;
  logic        rst_n    = 1'b0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [71:0] s_tdata  = '0;
  logic        s_tlast  = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;
  logic        m_tuser;
  logic        m_tlast;

  // Shadow decoder state, updated on every accepted request.
  logic [u16u32_pkg::PAYLOAD_W-1:0] hi_payload = '0;
  logic                             hi_held    = 1'b0;
  logic                             err_sticky = 1'b0;

  // Results owed by the decoder, oldest first.
  point_t points_due[$];

  bit     tx_idle_on     = 1'b1;
  bit     rx_idle_on     = 1'b1;
  int     mismatches     = 0;
  int     requests_sent  = 0;
  int     points_checked = 0;
  fault_e fault_kind     = FAULT_HIGH_HIGH;

  utf16_to_utf32_decoder #(
    .UNITS_PER_ITEM(UNITS_PER_ITEM)
  ) dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .s_axis_tvalid_i(s_tvalid),
    .s_axis_tready_o(s_tready),
    .s_axis_tdata_i (s_tdata),
    .s_axis_tlast_i (s_tlast),
    .m_axis_tvalid_o(m_tvalid),
    .m_axis_tready_i(m_tready),
    .m_axis_tdata_o (m_tdata),
    .m_axis_tuser_o (m_tuser),
    .m_axis_tlast_o (m_tlast)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic u16u32_pkg::unit_arr_t pack_units(
      input logic [u16u32_pkg::UNIT_W-1:0] a, b, c, d);
    return {d, c, b, a};
  endfunction

  function automatic point_t make_point(input logic [u16u32_pkg::CP_W-1:0] cp,
                                        input logic err);
    point_t p;
    p.res.code_point = cp;
    p.res.error      = err;
    p.last           = 1'b0;
    return p;
  endfunction

  // Decode one accepted request in the shadow state and queue what it owes.
  task automatic decode_request(input u16u32_pkg::unit_arr_t units,
                                input logic [u16u32_pkg::COUNT_W-1:0] count,
                                input logic eos);
    point_t                        batch[$];
    point_t                        p;
    logic [u16u32_pkg::UNIT_W-1:0] u;
    logic [u16u32_pkg::CP_W-1:0]   cp;
    logic                          fault;
    int                            n_units;
    int                            i;
    // Once a fault is latched, every request gets one bare error result.
    if (err_sticky) begin
      p = make_point('0, 1'b1);
      p.last = 1'b1;
      points_due.push_back(p);
      return;
    end
    n_units = (count > MAX_UNITS) ? MAX_UNITS : count;
    fault = 1'b0;
    for (i = 0; i < n_units && !fault; i++) begin
      u = units[i];
      if ((u & u16u32_pkg::SURR_MASK) == u16u32_pkg::HIGH_TAG) begin
        // A second high surrogate while one is open breaks the pair.
        if (hi_held) begin
          fault = 1'b1;
        end else begin
          hi_payload = u[u16u32_pkg::PAYLOAD_W-1:0];
          hi_held    = 1'b1;
        end
      end else if ((u & u16u32_pkg::SURR_MASK) == u16u32_pkg::LOW_TAG) begin
        if (hi_held) begin
          cp = u16u32_pkg::PLANE_OFFSET
               + {1'b0, hi_payload, u[u16u32_pkg::PAYLOAD_W-1:0]};
          batch.push_back(make_point(cp, 1'b0));
          hi_held    = 1'b0;
          hi_payload = '0;
        end else begin
          fault = 1'b1;
        end
      end else begin
        if (hi_held) begin
          fault = 1'b1;
        end else begin
          batch.push_back(make_point(u16u32_pkg::CP_W'(u), 1'b0));
        end
      end
    end
    // A high surrogate still open at end of stream is unpaired too.
    if (!fault && eos && hi_held) fault = 1'b1;
    if (fault) begin
      err_sticky = 1'b1;
      hi_held    = 1'b0;
      hi_payload = '0;
      batch.push_back(make_point('0, 1'b1));
    end
    if (batch.size() > 0) batch[batch.size()-1].last = 1'b1;
    foreach (batch[k]) points_due.push_back(batch[k]);
  endtask

  // Present one request, hold it until taken, then predict its results.
  task automatic send_request(input u16u32_pkg::unit_arr_t units,
                              input logic [u16u32_pkg::COUNT_W-1:0] count,
                              input logic eos);
    int gap;
    @(negedge clk);
    if (tx_idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 11);
      s_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tdata  = {5'b0, count, units};
    s_tlast  = eos;
    s_tvalid = 1'b1;
    do @(posedge clk); while (!s_tready);
    decode_request(units, count, eos);
    requests_sent++;
  endtask

  // Build a well-formed request with random content: close any open high
  // surrogate first, and raise end of stream only when nothing stays open.
  task automatic send_random_request();
    u16u32_pkg::unit_arr_t          units;
    logic [u16u32_pkg::COUNT_W-1:0] count;
    logic [u16u32_pkg::UNIT_W-1:0]  v;
    logic                           open;
    logic                           eos;
    int                             pick;
    int                             n_units;
    int                             i;
    pick = $urandom_range(0, 19);
    if (pick == 0) count = '0;
    else if (pick == 1) count = u16u32_pkg::COUNT_W'($urandom_range(5, 7));
    else count = u16u32_pkg::COUNT_W'($urandom_range(1, 4));
    n_units = (count > MAX_UNITS) ? MAX_UNITS : count;
    open = hi_held;
    for (i = 0; i < u16u32_pkg::UNIT_FIELDS; i++) begin
      if (i >= n_units) begin
        // Unused slots carry noise, surrogates included.
        units[i] = u16u32_pkg::UNIT_W'($urandom_range(0, 16'hffff));
      end else if (open) begin
        units[i] = u16u32_pkg::LOW_TAG | u16u32_pkg::UNIT_W'($urandom_range(0, 1023));
        open = 1'b0;
      end else if ($urandom_range(0, 3) == 0) begin
        units[i] = u16u32_pkg::HIGH_TAG | u16u32_pkg::UNIT_W'($urandom_range(0, 1023));
        open = 1'b1;
      end else begin
        do v = u16u32_pkg::UNIT_W'($urandom_range(0, 16'hffff));
        while ((v & 16'hf800) == 16'hd800);
        units[i] = v;
      end
    end
    eos = !open && ($urandom_range(0, 7) == 0);
    send_request(units, count, eos);
  endtask

  task automatic report_mismatch(input string field, input logic [31:0] expected,
                                 input logic [31:0] actual);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("tb_top: mismatch on %s at result %0d: expected %h, got %h",
               field, points_checked, expected, actual);
  endtask

  // Result side: stall in bursts, check each taken result against the oldest
  // one owed.
  initial begin : result_sink
    int     stall;
    point_t want;
    stall = 0;
    forever begin
      @(negedge clk);
      if (stall == 0 && rx_idle_on && $urandom_range(0, 5) == 0)
        stall = $urandom_range(1, 11);
      m_tready = (stall == 0);
      if (stall > 0) stall--;
      @(posedge clk);
      if (m_tvalid && m_tready) begin
        points_checked++;
        if (points_due.size() == 0) begin
          report_mismatch("result with nothing owed", '0,
                          32'({m_tlast, m_tuser, m_tdata}));
        end else begin
          want = points_due.pop_front();
          if (m_tdata !== {3'b0, want.res.code_point})
            report_mismatch("code_point", 32'(want.res.code_point), 32'(m_tdata));
          if (m_tuser !== want.res.error)
            report_mismatch("error", 32'(want.res.error), 32'(m_tuser));
          if (m_tlast !== want.last)
            report_mismatch("last_of_item", 32'(want.last), 32'(m_tlast));
        end
      end
    end
  end

  // End the run if neither side moves for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
      else quiet++;
    end
    $display("tb_top: no transfer for %0d cycles", QUIET_LIMIT);
    $display("tb_top: done, errors");
    $finish;
  end

  // Plain units at the edges of the non-surrogate ranges; in most requests the
  // slots past the count hold surrogates that must be ignored.
  task automatic test_plain_units();
    send_request(pack_units(16'h0000, 16'hffff, 16'hd7ff, 16'he000), 3'd4, 1'b0);
    send_request(pack_units(16'h0041, 16'hd800, 16'hdc00, 16'hffff), 3'd1, 1'b0);
    send_request(pack_units(16'haaaa, 16'h5555, 16'h1234, 16'hdead), 3'd3, 1'b0);
    send_request(pack_units(16'h007f, 16'h0080, 16'hdbff, 16'hdfff), 3'd2, 1'b0);
    send_request(pack_units(16'hfffe, 16'h0000, 16'h0000, 16'h0000), 3'd1, 1'b1);
  endtask

  // Pairs at the plane limits, inside one request and split across two.
  task automatic test_surrogate_pairs();
    send_request(pack_units(16'hd800, 16'hdc00, 16'hdbff, 16'hdfff), 3'd4, 1'b0);
    send_request(pack_units(16'h0031, 16'hd83d, 16'hde00, 16'h0032), 3'd4, 1'b0);
    // Leave a high surrogate open in the last slot, close it next request.
    send_request(pack_units(16'h0033, 16'h0034, 16'h0035, 16'hdbc0), 3'd4, 1'b0);
    send_request(pack_units(16'hdc01, 16'h0036, 16'hd800, 16'hd800), 3'd2, 1'b0);
    // A lone high surrogate gives no result until its partner arrives.
    send_request(pack_units(16'hd801, 16'h0000, 16'h0000, 16'h0000), 3'd1, 1'b0);
    send_request(pack_units(16'hdffe, 16'h0000, 16'h0000, 16'h0000), 3'd1, 1'b1);
  endtask

  // Zero counts, with and without an open surrogate, and oversized counts.
  task automatic test_count_edges();
    send_request(pack_units(16'h0050, 16'h0051, 16'h0052, 16'h0053), 3'd0, 1'b0);
    send_request(pack_units(16'hd800, 16'hdc00, 16'h0000, 16'h0000), 3'd0, 1'b1);
    send_request(pack_units(16'hd852, 16'h0000, 16'h0000, 16'h0000), 3'd1, 1'b0);
    send_request(pack_units(16'hdc00, 16'hdc00, 16'hdc00, 16'hdc00), 3'd0, 1'b0);
    send_request(pack_units(16'hdc52, 16'h0037, 16'h0038, 16'h0039), 3'd5, 1'b0);
    send_request(pack_units(16'h0040, 16'h0041, 16'h0042, 16'h0043), 3'd7, 1'b0);
    send_request(pack_units(16'h0044, 16'hd800, 16'hdc00, 16'h0045), 3'd6, 1'b1);
  endtask

  task automatic test_random_stream(input int n_requests, input bit idle);
    int i;
    tx_idle_on = idle;
    rx_idle_on = idle;
    for (i = 0; i < n_requests; i++) send_random_request();
  endtask

  // Stop sending until every owed result has drained, then resume.
  task automatic test_pause_until_drained();
    int i;
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    for (i = 0; i < 10; i++) send_random_request();
    @(negedge clk);
    s_tvalid = 1'b0;
    while (points_due.size() != 0) @(posedge clk);
    for (i = 0; i < 10; i++) send_random_request();
  endtask

  // Break the stream once, then check that the fault sticks: any later
  // request, whatever its content, returns one bare error result.
  task automatic test_sticky_error();
    logic [u16u32_pkg::UNIT_W-1:0] hi;
    int                            i;
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    if (hi_held)
      send_request(pack_units(16'hdc2a, 16'h0000, 16'h0000, 16'h0000), 3'd1, 1'b0);
    hi = u16u32_pkg::HIGH_TAG | u16u32_pkg::UNIT_W'($urandom_range(0, 1023));
    fault_kind = fault_e'($urandom_range(0, 3));
    // Each break comes after a plain unit, which must still come out first.
    case (fault_kind)
      FAULT_HIGH_HIGH: begin
        send_request(pack_units(16'h0061, hi, 16'hd9ff, 16'h0062), 3'd4, 1'b0);
      end
      FAULT_HIGH_PLAIN: begin
        send_request(pack_units(16'h0061, hi, 16'h0030, 16'hdc00), 3'd4, 1'b0);
      end
      FAULT_LONE_LOW: begin
        send_request(pack_units(16'h0061, 16'h0062, 16'hdc00 | hi[9:0], 16'h0063),
                     3'd3, 1'b0);
      end
      default: begin
        send_request(pack_units(16'h0061, hi, 16'h0000, 16'h0000), 3'd2, 1'b1);
      end
    endcase
    for (i = 0; i < 6; i++)
      send_request(u16u32_pkg::unit_arr_t'({$urandom, $urandom}),
                   u16u32_pkg::COUNT_W'($urandom_range(0, 7)),
                   1'($urandom_range(0, 1)));
  endtask

  initial begin : stimulus
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_plain_units();
    test_surrogate_pairs();
    test_count_edges();
    test_random_stream(50, 1'b1);
    test_pause_until_drained();
    test_random_stream(35, 1'b1);
    test_random_stream(40, 1'b0);
    test_sticky_error();

    // Drop valid, drain what is owed, then give the pipeline time to show
    // any stray result.
    @(negedge clk);
    s_tvalid = 1'b0;
    while (points_due.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("tb_top: %0d requests sent, %0d results taken, %0d mismatches",
             requests_sent, points_checked, mismatches);
    $display("tb_top: covered pairs across requests, zero and oversized counts, %s",
             fault_kind.name());
    if (mismatches == 0 && points_due.size() == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
